// File: src/cdsm_pkg.sv
// shared constants and types for the clock drift streak monitor
// no dependencies; used by the interfaces, the judge and the top level
package cdsm_pkg;

    localparam int TIME_BITS_DEF = 48;
    localparam int DELTA_W       = 16;
    localparam int ELAPSED_W     = 32;
    localparam int WINDOW_W      = 24;
    localparam int TOL_W         = 16;
    localparam int STREAK_W      = 8;
    localparam int PHASE_W       = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 24;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 2'd2;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET    = 24'd10000;
    localparam logic [TOL_W-1:0]    TOLERANCE_RESET = 16'd100;
    localparam logic [STREAK_W-1:0] THRESHOLD_RESET = 8'd3;

endpackage

// File: src/cdsm_in_if.sv
// input channel of the clock drift streak monitor: start and tick beats
// depends on cdsm_pkg for field widths
interface cdsm_in_if #(
    parameter int TIME_BITS = cdsm_pkg::TIME_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [cdsm_pkg::DELTA_W-1:0] delta_ms;
    logic [TIME_BITS-1:0]         boot_ms;
    logic [TIME_BITS-1:0]         wall_ms;

    modport source (output valid, kind, delta_ms, boot_ms, wall_ms, input ready);
    modport sink   (input valid, kind, delta_ms, boot_ms, wall_ms, output ready);
endinterface

// File: src/cdsm_out_if.sv
// result channel of the clock drift streak monitor
// depends on cdsm_pkg for field widths
interface cdsm_out_if;
    logic                          valid;
    logic                          ready;
    logic                          alarm;
    logic                          window_closed;
    logic                          window_anomalous;
    logic [cdsm_pkg::STREAK_W-1:0] streak_count;
    logic [cdsm_pkg::PHASE_W-1:0]  phase_now;

    modport source (output valid, alarm, window_closed, window_anomalous, streak_count,
                    phase_now, input ready);
    modport sink   (input valid, alarm, window_closed, window_anomalous, streak_count,
                    phase_now, output ready);
endinterface

// File: src/cdsm_judge.sv
// window judge: signed monotonic and wall intervals and the tolerance check
// depends on cdsm_pkg for the tolerance width
module cdsm_judge #(
    parameter int TIME_BITS = cdsm_pkg::TIME_BITS_DEF
) (
    input  logic [TIME_BITS-1:0]         i_boot,
    input  logic [TIME_BITS-1:0]         i_wall,
    input  logic [TIME_BITS-1:0]         i_boot_begin,
    input  logic [TIME_BITS-1:0]         i_wall_begin,
    input  logic [cdsm_pkg::TOL_W-1:0]   i_tolerance,
    output logic                         o_ok
);
    logic [TIME_BITS-1:0] boot_ival;
    logic [TIME_BITS-1:0] wall_ival;
    logic [TIME_BITS:0]   gain;
    logic [TIME_BITS:0]   tol_ext;

    assign boot_ival = i_boot - i_boot_begin;
    assign wall_ival = i_wall - i_wall_begin;
    // wall gain over monotonic, exact in one extra bit
    assign gain      = {wall_ival[TIME_BITS-1], wall_ival} - {boot_ival[TIME_BITS-1], boot_ival};
    assign tol_ext   = {{(TIME_BITS + 1 - cdsm_pkg::TOL_W){1'b0}}, i_tolerance};
    assign o_ok      = $signed(gain) <= $signed(tol_ext);
endmodule

// File: src/clock_drift_streak_monitor.sv
// clock drift streak monitor top level: phase control, window timing, result register
// latency: a result is valid the cycle after its input beat is accepted
// throughput: one beat per cycle while o_out drains; the state update passes once
// through the judge's interval subtractors and elapsed saturating adder each cycle
// reset (synchronous, active low): phase idle, streak zero, no window judged yet,
// configuration back to defaults, result register empty
module clock_drift_streak_monitor #(
    parameter int TIME_BITS = cdsm_pkg::TIME_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    cdsm_in_if.sink                          i_in,
    cdsm_out_if.source                       o_out,
    input  logic                             i_cfg_we,
    input  logic [cdsm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [cdsm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    typedef enum logic [cdsm_pkg::PHASE_W-1:0] {
        PH_IDLE  = 2'd0,
        PH_START = 2'd1,
        PH_CHECK = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        V_FIRST = 2'd0,
        V_OK    = 2'd1,
        V_ANOM  = 2'd2
    } t_verdict;

    t_phase                          r_phase, n_phase;
    t_verdict                        r_verdict, n_verdict;
    logic [cdsm_pkg::STREAK_W-1:0]   r_streak, n_streak;
    logic [cdsm_pkg::ELAPSED_W-1:0]  r_elapsed, n_elapsed;
    logic [TIME_BITS-1:0]            r_boot_begin, n_boot_begin;
    logic [TIME_BITS-1:0]            r_wall_begin, n_wall_begin;

    logic [cdsm_pkg::WINDOW_W-1:0]   r_window_len;
    logic [cdsm_pkg::TOL_W-1:0]      r_tolerance;
    logic [cdsm_pkg::STREAK_W-1:0]   r_threshold;

    logic                            r_out_valid;
    logic                            r_out_alarm, n_alarm;
    logic                            r_out_closed, n_closed;
    logic                            r_out_anom, n_anom;
    logic [cdsm_pkg::STREAK_W-1:0]   r_out_streak;
    t_phase                          r_out_phase;

    logic                            in_ready;
    logic                            accept;
    logic                            window_ok;
    logic [cdsm_pkg::ELAPSED_W:0]    elapsed_sum;
    logic [cdsm_pkg::ELAPSED_W-1:0]  elapsed_sat;
    logic [cdsm_pkg::STREAK_W-1:0]   streak_inc;

    assign in_ready   = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    cdsm_judge #(
        .TIME_BITS (TIME_BITS)
    ) u_judge (
        .i_boot       (i_in.boot_ms),
        .i_wall       (i_in.wall_ms),
        .i_boot_begin (r_boot_begin),
        .i_wall_begin (r_wall_begin),
        .i_tolerance  (r_tolerance),
        .o_ok         (window_ok)
    );

    assign elapsed_sum = {1'b0, r_elapsed}
                       + {{(cdsm_pkg::ELAPSED_W + 1 - cdsm_pkg::DELTA_W){1'b0}}, i_in.delta_ms};
    assign elapsed_sat = elapsed_sum[cdsm_pkg::ELAPSED_W] ? '1
                                                          : elapsed_sum[cdsm_pkg::ELAPSED_W-1:0];
    assign streak_inc  = (r_streak == '1) ? r_streak : r_streak + 1'b1;

    always_comb begin
        n_phase      = r_phase;
        n_verdict    = r_verdict;
        n_streak     = r_streak;
        n_elapsed    = r_elapsed;
        n_boot_begin = r_boot_begin;
        n_wall_begin = r_wall_begin;
        n_alarm      = 1'b0;
        n_closed     = 1'b0;
        n_anom       = 1'b0;
        if (i_in.kind == cdsm_pkg::KIND_START) begin
            n_phase   = PH_START;
            n_streak  = '0;
            n_verdict = V_FIRST;
        end else begin
            unique case (r_phase)
                PH_START: begin
                    n_phase      = PH_CHECK;
                    n_elapsed    = '0;
                    n_boot_begin = i_in.boot_ms;
                    n_wall_begin = i_in.wall_ms;
                end
                PH_CHECK: begin
                    n_elapsed = elapsed_sat;
                    if (elapsed_sat >= {{(cdsm_pkg::ELAPSED_W - cdsm_pkg::WINDOW_W){1'b0}},
                                        r_window_len}) begin
                        n_closed = 1'b1;
                        if (window_ok) begin
                            n_verdict = V_OK;
                            n_phase   = PH_START;
                        end else begin
                            n_anom    = 1'b1;
                            n_verdict = V_ANOM;
                            n_phase   = PH_START;
                            if (r_verdict == V_OK) begin
                                n_streak = '0;
                            end else begin
                                n_streak = streak_inc;
                                if (streak_inc >= r_threshold) begin
                                    n_alarm = 1'b1;
                                    n_phase = PH_IDLE;
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_verdict    <= V_FIRST;
            r_streak     <= '0;
            r_window_len <= cdsm_pkg::WINDOW_RESET;
            r_tolerance  <= cdsm_pkg::TOLERANCE_RESET;
            r_threshold  <= cdsm_pkg::THRESHOLD_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    cdsm_pkg::CFG_WINDOW_LENGTH: r_window_len <= i_cfg_data;
                    cdsm_pkg::CFG_TOLERANCE:     r_tolerance  <= i_cfg_data[cdsm_pkg::TOL_W-1:0];
                    cdsm_pkg::CFG_THRESHOLD:     r_threshold  <= i_cfg_data[cdsm_pkg::STREAK_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_phase      <= n_phase;
                r_verdict    <= n_verdict;
                r_streak     <= n_streak;
                r_elapsed    <= n_elapsed;
                r_boot_begin <= n_boot_begin;
                r_wall_begin <= n_wall_begin;
                r_out_valid  <= 1'b1;
                r_out_alarm  <= n_alarm;
                r_out_closed <= n_closed;
                r_out_anom   <= n_anom;
                r_out_streak <= n_streak;
                r_out_phase  <= n_phase;
            end else if (o_out.ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.alarm            = r_out_alarm;
    assign o_out.window_closed    = r_out_closed;
    assign o_out.window_anomalous = r_out_anom;
    assign o_out.streak_count     = r_out_streak;
    assign o_out.phase_now        = r_out_phase;

    a_alarm_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_alarm) |-> (r_out_anom && r_out_closed && r_out_phase == PH_IDLE
                                          && r_phase == r_out_phase))
        else $error("alarm without anomalous closed window or idle phase");

    a_anom_needs_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_anom) |-> r_out_closed)
        else $error("anomalous flag on a beat that closed no window");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.kind == cdsm_pkg::KIND_START) |=>
            (r_out_valid && r_out_streak == '0 && r_out_phase == PH_START
             && r_verdict == V_FIRST))
        else $error("start beat did not clear streak and arm the monitor");
endmodule

// File: tb/clock_drift_streak_monitor_test.sv
`timescale 1ns / 1ps
// self-checking testbench for clock_drift_streak_monitor: directed windows, register limits,
// back-pressure and random window sequences, checked against an in-bench verdict predictor
// depends on cdsm_pkg, cdsm_in_if, cdsm_out_if and the monitor rtl
module clock_drift_streak_monitor_test;

    localparam int TB = cdsm_pkg::TIME_BITS_DEF;
    localparam int DW = cdsm_pkg::DELTA_W;
    localparam int CW = cdsm_pkg::CFG_DATA_W;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [cdsm_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [TB-1:0] TIME_MAX = '1;

    typedef enum logic [cdsm_pkg::PHASE_W-1:0] {
        PHASE_IDLE  = 2'd0,
        PHASE_START = 2'd1,
        PHASE_CHECK = 2'd2
    } t_drift_phase;

    typedef enum logic [1:0] {
        VERDICT_FIRST,
        VERDICT_OK,
        VERDICT_ANOM
    } t_verdict;

    typedef struct packed {
        logic                          kind;
        logic [DW-1:0]                 delta;
        logic [TB-1:0]                 boot;
        logic [TB-1:0]                 wall;
    } t_tick_beat;

    typedef struct packed {
        logic                          alarm;
        logic                          closed;
        logic                          anom;
        logic [cdsm_pkg::STREAK_W-1:0] streak;
        logic [cdsm_pkg::PHASE_W-1:0]  phase;
    } t_drift_result;

    logic i_clk;
    logic i_rst_n;
    logic                           i_cfg_we;
    logic [cdsm_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [CW-1:0]                  i_cfg_data;

    cdsm_in_if #(.TIME_BITS(TB)) tick_bus ();
    cdsm_out_if                  verdict_bus ();

    clock_drift_streak_monitor #(.TIME_BITS(TB)) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (tick_bus),
        .o_out      (verdict_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // predictor state and its copy of the registers
    t_drift_phase                   drift_phase;
    t_verdict                       last_verdict;
    logic [cdsm_pkg::ELAPSED_W-1:0] elapsed_ms;
    logic [TB-1:0]                  boot_start;
    logic [TB-1:0]                  wall_start;
    logic [cdsm_pkg::STREAK_W-1:0]  streak;
    logic [cdsm_pkg::WINDOW_W-1:0]  window_len;
    logic [cdsm_pkg::TOL_W-1:0]     tolerance;
    logic [cdsm_pkg::STREAK_W-1:0]  threshold;

    t_drift_result pending_verdicts[$];
    int unsigned   mismatch_count;
    int unsigned   cycle_count;
    int unsigned   send_idle_pct;
    int unsigned   sink_stall_pct;
    int            hold_off_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [TB-1:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[TB-1:0];
    endfunction

    function automatic t_drift_result predict_verdict(input t_tick_beat b);
        t_drift_result r;
        logic [cdsm_pkg::ELAPSED_W:0] sum;
        logic signed [TB-1:0] boot_iv;
        logic signed [TB-1:0] wall_iv;
        r = '0;
        if (b.kind == cdsm_pkg::KIND_START) begin
            drift_phase  = PHASE_START;
            streak       = '0;
            last_verdict = VERDICT_FIRST;
        end else if (drift_phase == PHASE_START) begin
            drift_phase = PHASE_CHECK;
            elapsed_ms  = '0;
            boot_start  = b.boot;
            wall_start  = b.wall;
        end else if (drift_phase == PHASE_CHECK) begin
            sum = {1'b0, elapsed_ms} + b.delta;
            elapsed_ms = sum[cdsm_pkg::ELAPSED_W] ? '1 : sum[cdsm_pkg::ELAPSED_W-1:0];
            if (elapsed_ms >= window_len) begin
                boot_iv = b.boot - boot_start;
                wall_iv = b.wall - wall_start;
                r.closed = 1'b1;
                if (boot_iv >= wall_iv ||
                    longint'(wall_iv) - longint'(boot_iv) <= longint'(tolerance)) begin
                    last_verdict = VERDICT_OK;
                    drift_phase  = PHASE_START;
                end else begin
                    r.anom = 1'b1;
                    if (last_verdict != VERDICT_OK) begin
                        if (streak != '1)
                            streak++;
                        if (streak >= threshold) begin
                            r.alarm     = 1'b1;
                            drift_phase = PHASE_IDLE;
                        end else begin
                            drift_phase = PHASE_START;
                        end
                    end else begin
                        streak      = '0;
                        drift_phase = PHASE_START;
                    end
                    last_verdict = VERDICT_ANOM;
                end
            end
        end
        r.streak = streak;
        r.phase  = drift_phase;
        return r;
    endfunction

    // picks the next beat from the predicted phase so most windows are well formed
    function automatic t_tick_beat pick_beat();
        t_tick_beat b;
        logic [TB-1:0] boot_iv;
        logic [TB-1:0] gain;
        logic [cdsm_pkg::ELAPSED_W:0] sum;
        int unsigned roll;
        roll = $urandom_range(99);
        b.kind = cdsm_pkg::KIND_TICK;
        b.boot = rand48();
        b.wall = rand48();
        case ($urandom_range(9))
            0:       b.delta = '0;
            1:       b.delta = '1;
            2, 3:    b.delta = DW'($urandom);
            default: b.delta = DW'($urandom_range(0, (window_len / 3 > 65534) ?
                                                  65535 : window_len / 3 + 1));
        endcase
        if (roll < 6) begin
            b.kind = $urandom_range(1) ? cdsm_pkg::KIND_START : cdsm_pkg::KIND_TICK;
        end else if (drift_phase == PHASE_IDLE) begin
            b.kind = cdsm_pkg::KIND_START;
        end else if (drift_phase == PHASE_CHECK) begin
            sum = {1'b0, elapsed_ms} + b.delta;
            if (roll < 10) begin
                b.kind = cdsm_pkg::KIND_START;
            end else if (sum >= window_len) begin
                case ($urandom_range(3))
                    0:       boot_iv = rand48();
                    1:       boot_iv = '0 - TB'($urandom_range(1, 1000));
                    default: boot_iv = TB'($urandom_range(0, 100000));
                endcase
                case ($urandom_range(7))
                    0:       gain = TB'(tolerance);
                    1:       gain = TB'(tolerance) + TB'(1);
                    2:       gain = TB'($urandom_range(0, tolerance));
                    3:       gain = '0 - TB'($urandom_range(1, 100000));
                    4:       gain = rand48();
                    default: gain = TB'(tolerance) + TB'(1) + TB'($urandom_range(0, 100000));
                endcase
                b.boot = boot_start + boot_iv;
                b.wall = wall_start + boot_iv + gain;
            end
        end
        return b;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_drift_result want;
        if (i_rst_n && verdict_bus.valid && verdict_bus.ready) begin
            if (pending_verdicts.size() == 0) begin
                $error("result beat with nothing expected");
                mismatch_count++;
            end else begin
                want = pending_verdicts.pop_front();
                check_field("alarm", 8'(want.alarm), 8'(verdict_bus.alarm));
                check_field("window_closed", 8'(want.closed), 8'(verdict_bus.window_closed));
                check_field("window_anomalous", 8'(want.anom),
                            8'(verdict_bus.window_anomalous));
                check_field("streak_count", want.streak, verdict_bus.streak_count);
                check_field("phase_now", 8'(want.phase), 8'(verdict_bus.phase_now));
            end
        end
    end

    // result receiver with random stalls and long hold-offs
    initial begin
        verdict_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                verdict_bus.ready = 1'b0;
                hold_off_cycles--;
            end else begin
                verdict_bus.ready = ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    task automatic send_beat(input t_tick_beat b);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            tick_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        tick_bus.valid    = 1'b1;
        tick_bus.kind     = b.kind;
        tick_bus.delta_ms = b.delta;
        tick_bus.boot_ms  = b.boot;
        tick_bus.wall_ms  = b.wall;
        @(posedge i_clk);
        while (!tick_bus.ready)
            @(posedge i_clk);
        pending_verdicts.push_back(predict_verdict(b));
    endtask

    task automatic send_item(input logic kind, input logic [DW-1:0] delta,
                             input logic [TB-1:0] boot, input logic [TB-1:0] wall);
        t_tick_beat b;
        b.kind  = kind;
        b.delta = delta;
        b.boot  = boot;
        b.wall  = wall;
        send_beat(b);
    endtask

    // capture tick then a closing tick
    task automatic send_window(input logic [DW-1:0] delta,
                               input logic [TB-1:0] boot0, input logic [TB-1:0] wall0,
                               input logic [TB-1:0] boot1, input logic [TB-1:0] wall1);
        send_item(cdsm_pkg::KIND_TICK, DW'($urandom), boot0, wall0);
        send_item(cdsm_pkg::KIND_TICK, delta, boot1, wall1);
    endtask

    task automatic send_start();
        send_item(cdsm_pkg::KIND_START, DW'($urandom), rand48(), rand48());
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        tick_bus.valid = 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [cdsm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [CW-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        case (idx)
            cdsm_pkg::CFG_WINDOW_LENGTH: window_len = data;
            cdsm_pkg::CFG_TOLERANCE:     tolerance  = data[cdsm_pkg::TOL_W-1:0];
            cdsm_pkg::CFG_THRESHOLD:     threshold  = data[cdsm_pkg::STREAK_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic apply_settings(input logic [CW-1:0] w, input logic [CW-1:0] t,
                                  input logic [CW-1:0] h);
        wait_for_results();
        write_reg(cdsm_pkg::CFG_WINDOW_LENGTH, w);
        write_reg(cdsm_pkg::CFG_TOLERANCE, t);
        write_reg(cdsm_pkg::CFG_THRESHOLD, h);
    endtask

    task automatic test_directed_windows();
        int k;
        send_item(cdsm_pkg::KIND_TICK, '1, TIME_MAX, TIME_MAX);
        send_start();
        send_item(cdsm_pkg::KIND_TICK, '0, '0, '0);
        send_item(cdsm_pkg::KIND_TICK, '0, 48'd1, 48'd1);
        // gain exactly at tolerance
        send_item(cdsm_pkg::KIND_TICK, '1, 48'd5000, 48'd5100);
        // both readings wrap, gain one over tolerance after an ok window
        send_window(16'hAAAA, 48'hFFFF_FFFF_FFF0, TIME_MAX, 48'h10, 48'd132);
        send_window(16'd10000, 48'd100, 48'd0, 48'd100, 48'h7FFF_FFFF_FFFF);
        send_start();
        send_window(16'd10000, 48'd0, 48'h8000_0000_0000, 48'd0, 48'd0);
        send_start();
        send_window(16'd10000, 48'd1000, 48'd2000, 48'd1000, 48'd2101);
        // start while checking clears the streak
        send_item(cdsm_pkg::KIND_TICK, 16'd1, 48'd2, 48'd3);
        send_start();
        for (k = 0; k < 3; k++)
            send_window('1, 48'hABCD, 48'h1234, 48'hABCD + 48'd10, 48'h1234 + 48'd500);
        send_item(cdsm_pkg::KIND_TICK, '1, '0, TIME_MAX);
        wait_for_results();
    endtask

    task automatic test_register_limits();
        apply_settings(24'd0, 24'hFF0000, 24'hFFFF00);
        write_reg(CFG_UNUSED, 24'hFFFFFF);
        send_start();
        send_window('0, 48'd5, 48'd5, 48'd9, 48'd9);
        send_window('0, 48'd5, 48'd5, 48'd5, 48'd6);
        send_window('0, 48'd5, 48'd5, 48'd5, 48'd6);
        apply_settings(24'hFFFFFF, 24'h12FFFF, 24'h00FFFF);
        send_start();
        send_item(cdsm_pkg::KIND_TICK, '1, rand48(), rand48());
        send_item(cdsm_pkg::KIND_TICK, '1, rand48(), rand48());
        send_item(cdsm_pkg::KIND_TICK, '1, rand48(), rand48());
        wait_for_results();
    endtask

    task automatic test_back_pressure();
        int n;
        apply_settings(24'd40, 24'd20, 24'd2);
        hold_off_cycles = 60;
        for (n = 0; n < 40; n++)
            send_beat(pick_beat());
        wait_for_results();
    endtask

    task automatic test_full_streak();
        int k;
        logic [TB-1:0] b0;
        logic [TB-1:0] w0;
        apply_settings(24'd0, 24'd0, 24'd255);
        send_start();
        for (k = 0; k < 255; k++) begin
            b0 = rand48();
            w0 = rand48();
            send_window(DW'($urandom), b0, w0, b0 + TB'(k),
                        w0 + TB'(k) + TB'(1) + TB'($urandom_range(0, 999)));
        end
        send_item(cdsm_pkg::KIND_TICK, '0, '0, '0);
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int chunks, input int per_chunk);
        int c;
        int sent;
        t_tick_beat b;
        logic [CW-1:0] w;
        logic [CW-1:0] t;
        logic [CW-1:0] h;
        for (c = 0; c < chunks; c++) begin
            case ($urandom_range(15))
                0:          w = '1;
                1, 2:       w = '0;
                3, 4, 5, 6: w = CW'($urandom_range(1, 300));
                default:    w = CW'($urandom_range(300, 150000));
            endcase
            case ($urandom_range(5))
                0:       t = '0;
                1:       t = 24'h00FFFF;
                2, 3:    t = CW'($urandom_range(0, 200));
                default: t = CW'($urandom_range(0, 65535));
            endcase
            case ($urandom_range(7))
                0:       h = '0;
                1:       h = 24'd255;
                default: h = CW'($urandom_range(1, 4));
            endcase
            t[CW-1:cdsm_pkg::TOL_W]    = (CW - cdsm_pkg::TOL_W)'($urandom);
            h[CW-1:cdsm_pkg::STREAK_W] = (CW - cdsm_pkg::STREAK_W)'($urandom);
            apply_settings(w, t, h);
            sent = 0;
            while (sent < per_chunk) begin
                b = pick_beat();
                if (!(b.kind == cdsm_pkg::KIND_TICK && drift_phase == PHASE_IDLE))
                    sent++;
                send_beat(b);
            end
        end
        wait_for_results();
    endtask

    initial begin
        tick_bus.valid    = 1'b0;
        tick_bus.kind     = cdsm_pkg::KIND_START;
        tick_bus.delta_ms = '0;
        tick_bus.boot_ms  = '0;
        tick_bus.wall_ms  = '0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = cdsm_pkg::CFG_WINDOW_LENGTH;
        i_cfg_data        = '0;
        i_rst_n           = 1'b0;
        mismatch_count    = 0;
        cycle_count       = 0;
        hold_off_cycles   = 0;
        drift_phase       = PHASE_IDLE;
        last_verdict      = VERDICT_FIRST;
        elapsed_ms        = '0;
        boot_start        = '0;
        wall_start        = '0;
        streak            = '0;
        window_len        = cdsm_pkg::WINDOW_RESET;
        tolerance         = cdsm_pkg::TOLERANCE_RESET;
        threshold         = cdsm_pkg::THRESHOLD_RESET;
        send_idle_pct     = 8;
        sink_stall_pct    = 73;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_windows();
        test_register_limits();
        test_back_pressure();
        test_random_traffic(4, 115);

        send_idle_pct  = 73;
        sink_stall_pct = 8;
        test_full_streak();
        test_random_traffic(4, 115);

        send_idle_pct  = 0;
        sink_stall_pct = 0;
        test_random_traffic(4, 115);

        wait_for_results();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// File: filelist.f
src/cdsm_pkg.sv
src/cdsm_in_if.sv
src/cdsm_out_if.sv
src/cdsm_judge.sv
src/clock_drift_streak_monitor.sv
tb/clock_drift_streak_monitor_test.sv
